// ===== hdl/mrrc_pkg.sv =====
// Shared types, constants and the CRC helper for the Modbus RTU reply checker.
package mrrc_pkg;

    // Frame and protocol constants
    localparam int          DEF_MAX_FRAME = 32;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FUNC_READ     = 8'h03;
    localparam int          MIN_LEN       = 5;
    localparam logic [3:0]  MAX_REGS      = 4'd13;

    // Configuration register map
    localparam int          PADDR_W          = 3;
    localparam logic        REG_SLAVE_ADDR   = 1'b0;
    localparam logic        REG_REG_COUNT    = 1'b1;
    localparam logic [7:0]  RST_SLAVE_ADDR   = 8'd1;
    localparam logic [3:0]  RST_REG_COUNT    = 4'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CRC       = 3'd2,
        ST_ADDR_FUNC = 3'd3,
        ST_EXCEPTION = 3'd4,
        ST_BYTE_CNT  = 3'd5
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic store_byte;   // accepted byte goes into the frame
        logic clr_frame;    // frame done, back to empty
        logic start_regs;   // first register result
        logic next_reg;     // advance to next register
        logic rd_lo;        // read low byte of current register
        logic cap_hi;       // capture high byte from read data
        logic load_status;  // load a status-only result
        logic load_reg;     // load a register result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic frame_ok;     // all checks passed
        logic out_last;     // held result is last of frame
    } t_dp_sts;

    // One byte folded into CRC-16/MODBUS, bit by bit
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/mrrc_if.sv =====
// Valid/ready channel interfaces for received bytes and checker results.
interface mrrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrrc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic        last;

    modport source (output valid, output status, output exception_code,
                    output reg_index, output reg_value, output last, input ready);
    modport sink   (input valid, input status, input exception_code,
                    input reg_index, input reg_value, input last, output ready);
endinterface

// ===== hdl/mrrc_regs.sv =====
// APB-style configuration registers: slave address and register count.
module mrrc_regs
    import mrrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [7:0]         o_slave_addr,
    output logic [3:0]         o_reg_count
);

    logic [7:0] r_slave_addr;
    logic [3:0] r_reg_count;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= RST_SLAVE_ADDR;
            r_reg_count  <= RST_REG_COUNT;
        end else if (wr_en) begin
            if (reg_sel == REG_SLAVE_ADDR) begin
                r_slave_addr <= pwdata[7:0];
            end else begin
                r_reg_count <= pwdata[3:0];
            end
        end
    end

    // Read back
    always_comb begin
        if (reg_sel == REG_REG_COUNT) begin
            prdata = {28'd0, r_reg_count};
        end else begin
            prdata = {24'd0, r_slave_addr};
        end
    end

    assign o_slave_addr = r_slave_addr;
    assign o_reg_count  = r_reg_count;

endmodule

// ===== hdl/mrrc_ctrl.sv =====
// Sequencer: byte intake, frame check, register readout and result handoff.
module mrrc_ctrl
    import mrrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_end,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_RD_HI = 6'b000100,
        S_RD_LO = 6'b001000,
        S_LOAD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store_byte = 1'b1;
                    if (i_in_end) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.frame_ok) begin
                    o_cmd.start_regs = 1'b1;
                    n_state          = S_RD_HI;
                end else begin
                    o_cmd.load_status = 1'b1;
                    n_state           = S_OUT;
                end
            end
            S_RD_HI: begin
                n_state = S_RD_LO;
            end
            S_RD_LO: begin
                o_cmd.rd_lo  = 1'b1;
                o_cmd.cap_hi = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_reg = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.clr_frame = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.next_reg = 1'b1;
                        n_state        = S_RD_HI;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mrrc_dpath.sv =====
// Datapath: frame memory, CRC, header capture, checks and result register.
module mrrc_dpath
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME = DEF_MAX_FRAME
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_slave_addr,
    input  logic [3:0]  i_reg_count,
    output logic [2:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic [3:0]  o_reg_index,
    output logic [15:0] o_reg_value,
    output logic        o_last
);

    localparam int            AW      = $clog2(MAX_FRAME);
    localparam int            CW      = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);

    // Frame memory
    logic [7:0]    r_frame_mem [MAX_FRAME];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;
    logic [5:0]    rd_addr_full;

    // Frame state
    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [7:0]    r_b0;        // second-to-last kept byte
    logic [7:0]    r_b1;        // last kept byte
    logic [7:0]    r_addr_byte;
    logic [7:0]    r_func;
    logic [7:0]    r_bcnt;
    logic [3:0]    r_idx;
    logic [7:0]    r_hi;

    // Result register
    logic [2:0]    r_status;
    logic [7:0]    r_exc;
    logic [3:0]    r_out_idx;
    logic [15:0]   r_value;
    logic          r_last;

    logic          keep;
    t_status       chk_code;
    logic          cnt_bad;
    logic [7:0]    exp_len;

    assign keep = i_cmd.store_byte && (r_count < MAX_CNT);

    // Memory write and registered read
    assign rd_addr_full = {1'b0, r_idx, 1'b0} + 6'd3 + {5'd0, i_cmd.rd_lo};
    assign rd_addr      = AW'(rd_addr_full);

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_frame_mem[r_count[AW-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_frame_mem[rd_addr];
    end

    // Byte count and CRC over all but the last two kept bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (i_cmd.clr_frame) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (keep) begin
            r_count <= r_count + 1'b1;
            if (r_count >= CW'(2)) begin
                r_crc <= crc_fold(r_crc, r_b0);
            end
        end
    end

    // Trailing bytes and header bytes
    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_b0 <= r_b1;
            r_b1 <= i_rx_byte;
            if (r_count == CW'(0)) begin
                r_addr_byte <= i_rx_byte;
            end
            if (r_count == CW'(1)) begin
                r_func <= i_rx_byte;
            end
            if (r_count == CW'(2)) begin
                r_bcnt <= i_rx_byte;
            end
        end
    end

    // Frame checks in priority order
    assign exp_len = 8'(MIN_LEN) + {3'd0, i_reg_count, 1'b0};
    assign cnt_bad = (i_reg_count == 4'd0) || (i_reg_count > MAX_REGS) ||
                     (r_bcnt != {3'd0, i_reg_count, 1'b0}) ||
                     (8'(r_count) != exp_len);

    always_comb begin
        if (r_count < CW'(MIN_LEN)) begin
            chk_code = ST_SHORT;
        end else if ({r_b1, r_b0} != r_crc) begin
            chk_code = ST_CRC;
        end else if (r_func[7]) begin
            chk_code = ST_EXCEPTION;
        end else if ((r_addr_byte != i_slave_addr) || (r_func != FUNC_READ)) begin
            chk_code = ST_ADDR_FUNC;
        end else if (cnt_bad) begin
            chk_code = ST_BYTE_CNT;
        end else begin
            chk_code = ST_OK;
        end
    end

    // Register index and high byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_regs) begin
            r_idx <= 4'd0;
        end else if (i_cmd.next_reg) begin
            r_idx <= r_idx + 4'd1;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= r_rd_data;
        end
    end

    // Result register load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_status) begin
            r_status  <= chk_code;
            r_exc     <= (chk_code == ST_EXCEPTION) ? r_bcnt : 8'd0;
            r_out_idx <= 4'd0;
            r_value   <= 16'd0;
            r_last    <= 1'b1;
        end else if (i_cmd.load_reg) begin
            r_status  <= ST_OK;
            r_exc     <= 8'd0;
            r_out_idx <= r_idx;
            r_value   <= {r_hi, r_rd_data};
            r_last    <= ((r_idx + 4'd1) == i_reg_count);
        end
    end

    assign o_sts.frame_ok = (chk_code == ST_OK);
    assign o_sts.out_last = r_last;

    assign o_status         = r_status;
    assign o_exception_code = r_exc;
    assign o_reg_index      = r_out_idx;
    assign o_reg_value      = r_value;
    assign o_last           = r_last;

endmodule

// ===== hdl/modbus_rtu_read_response_checker.sv =====
// Input bytes: one per cycle while waiting for frame end; ready stays low until the frame is done.
// A status-only result is loaded in S_CHECK after the frame-end byte is taken, valid in S_OUT;
// a register result passes S_RD_HI, S_RD_LO and S_LOAD (memory read of high byte, low byte, then
// load) after S_CHECK or the previous handoff. Ready returns the cycle after the last result.
// Synchronous active-low reset empties the frame, sets CRC to 0xFFFF, address 1, count 2.
// Frame memory contents are not cleared; only bytes of the current frame are read.
module modbus_rtu_read_response_checker
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME = DEF_MAX_FRAME
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mrrc_rx_if.sink            i_rx,
    mrrc_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] slave_addr;
    logic [3:0] reg_count;
    t_dp_cmd    cmd;
    t_dp_sts    sts;

    // Configuration registers
    mrrc_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_slave_addr (slave_addr),
        .o_reg_count  (reg_count)
    );

    // Controller
    mrrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .i_in_end    (i_rx.frame_end),
        .o_in_ready  (i_rx.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath
    mrrc_dpath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_rx_byte        (i_rx.rx_byte),
        .i_slave_addr     (slave_addr),
        .i_reg_count      (reg_count),
        .o_status         (o_res.status),
        .o_exception_code (o_res.exception_code),
        .o_reg_index      (o_res.reg_index),
        .o_reg_value      (o_res.reg_value),
        .o_last           (o_res.last)
    );

endmodule

// ===== bench/tb_modbus_rtu_read_response_checker.sv =====
// Self-checking testbench for the Modbus RTU read-holding-registers reply checker.
`timescale 1ns / 1ps

module tb_modbus_rtu_read_response_checker;
    import mrrc_pkg::*;

    localparam int          FRAME_CAP     = DEF_MAX_FRAME;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          LIMIT_CYCLES  = 200000;

    // Kinds of reply frame the stimulus can build
    typedef enum int {
        FK_GOOD,
        FK_EXCEPTION,
        FK_ADDR_FUNC,
        FK_COUNT_BAD,
        FK_CRC_BAD,
        FK_SHORT,
        FK_OVERLONG,
        FK_NOISE
    } t_frame_kind;

    // One expected result item
    typedef struct packed {
        t_status     status;
        logic [7:0]  exc_code;
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } t_reply_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    mrrc_rx_if  rx_if ();
    mrrc_res_if res_if ();

    modbus_rtu_read_response_checker #(
        .MAX_FRAME(FRAME_CAP)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Predictor state: frame bytes, kept count, running CRC and register copies
    logic [7:0]  frame_mem [FRAME_CAP];
    int          kept;
    logic [15:0] crc_run;
    logic [7:0]  cfg_addr;
    logic [3:0]  cfg_count;

    t_reply_word expected_words[$];
    logic [7:0]  tx_frame[$];
    int          mismatch_count;
    int          cycle_count;
    bit          idle_on;

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // CRC-16/MODBUS, one byte, reflected shift
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        r = acc ^ {8'h00, d};
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic add_expect(input t_status st, input logic [7:0] ec, input logic [3:0] ix,
                              input logic [15:0] v, input logic l);
        t_reply_word w;
        w.status   = st;
        w.exc_code = ec;
        w.index    = ix;
        w.value    = v;
        w.last     = l;
        expected_words.push_back(w);
    endtask

    // Fold one accepted byte into the predictor; at frame end queue the results
    task automatic predict_reply_byte(input logic [7:0] b, input logic fe);
        logic [15:0] rx_crc;
        if (kept < FRAME_CAP) begin
            if (kept >= 2) crc_run = crc16_step(crc_run, frame_mem[kept-2]);
            frame_mem[kept] = b;
            kept++;
        end
        if (fe) begin
            if (kept < MIN_LEN) begin
                add_expect(ST_SHORT, 8'h00, 4'd0, 16'h0000, 1'b1);
            end else begin
                rx_crc = {frame_mem[kept-1], frame_mem[kept-2]};
                if (rx_crc != crc_run) begin
                    add_expect(ST_CRC, 8'h00, 4'd0, 16'h0000, 1'b1);
                end else if ((frame_mem[1] & EXC_FLAG) != 8'h00) begin
                    add_expect(ST_EXCEPTION, frame_mem[2], 4'd0, 16'h0000, 1'b1);
                end else if (frame_mem[0] != cfg_addr || frame_mem[1] != FUNC_READ) begin
                    add_expect(ST_ADDR_FUNC, 8'h00, 4'd0, 16'h0000, 1'b1);
                end else if (cfg_count == 4'd0 || cfg_count > MAX_REGS ||
                             int'(frame_mem[2]) != 2 * int'(cfg_count) ||
                             kept != MIN_LEN + 2 * int'(cfg_count)) begin
                    add_expect(ST_BYTE_CNT, 8'h00, 4'd0, 16'h0000, 1'b1);
                end else begin
                    for (int i = 0; i < int'(cfg_count); i++) begin
                        add_expect(ST_OK, 8'h00, 4'(i),
                                   {frame_mem[3+2*i], frame_mem[4+2*i]},
                                   i == int'(cfg_count) - 1);
                    end
                end
            end
            kept    = 0;
            crc_run = CRC_INIT;
        end
    endtask

    // Result checker: compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_reply_word w;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result: status %0d index %0d",
                       res_if.status, res_if.reg_index);
                mismatch_count++;
            end else begin
                w = expected_words.pop_front();
                if (res_if.status !== w.status) begin
                    $error("status: expected %0d, got %0d", w.status, res_if.status);
                    mismatch_count++;
                end
                if (res_if.exception_code !== w.exc_code) begin
                    $error("exception_code: expected %0h, got %0h",
                           w.exc_code, res_if.exception_code);
                    mismatch_count++;
                end
                if (res_if.reg_index !== w.index) begin
                    $error("reg_index: expected %0d, got %0d", w.index, res_if.reg_index);
                    mismatch_count++;
                end
                if (res_if.reg_value !== w.value) begin
                    $error("reg_value: expected %0h, got %0h", w.value, res_if.reg_value);
                    mismatch_count++;
                end
                if (res_if.last !== w.last) begin
                    $error("last: expected %0b, got %0b", w.last, res_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Result side: random stall bursts on ready
    initial begin
        int hold;
        hold = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 4) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Send one byte, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic fe);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.rx_byte   <= b;
        rx_if.frame_end <= fe;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        predict_reply_byte(b, fe);
    endtask

    task automatic send_frame();
        for (int i = 0; i < tx_frame.size(); i++) begin
            send_byte(tx_frame[i], i == tx_frame.size() - 1);
        end
        tx_frame.delete();
    endtask

    // Stop sending and wait until every expected result is in
    task automatic wait_for_results_drained();
        @(negedge i_clk);
        rx_if.valid     <= 1'b0;
        rx_if.frame_end <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup then access phase
    task automatic write_config_reg(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_SLAVE_ADDR) cfg_addr = value[7:0];
        else cfg_count = value[3:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < tx_frame.size(); i++) c = crc16_step(c, tx_frame[i]);
        tx_frame.push_back(c[7:0]);
        tx_frame.push_back(c[15:8]);
    endtask

    task automatic append_random(input int n);
        repeat (n) tx_frame.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FK_GOOD;
        if (r < 65) return FK_EXCEPTION;
        if (r < 73) return FK_ADDR_FUNC;
        if (r < 81) return FK_COUNT_BAD;
        if (r < 89) return FK_CRC_BAD;
        if (r < 94) return FK_SHORT;
        if (r < 97) return FK_OVERLONG;
        return FK_NOISE;
    endfunction

    // Build one reply frame of the given kind into tx_frame
    task automatic build_frame(input t_frame_kind kind, input logic [7:0] addr,
                               input logic [3:0] count);
        int         nregs;
        logic [7:0] fn;
        logic [7:0] nbytes;
        nregs  = (count == 4'd0 || count > MAX_REGS) ? $urandom_range(1, 3) : int'(count);
        nbytes = {3'b000, count, 1'b0};
        tx_frame.delete();
        case (kind)
            FK_GOOD, FK_CRC_BAD: begin
                tx_frame.push_back(addr);
                tx_frame.push_back(FUNC_READ);
                tx_frame.push_back(nbytes);
                append_random(2 * nregs);
                append_crc();
                // corrupt one of the two CRC bytes
                if (kind == FK_CRC_BAD) begin
                    tx_frame[tx_frame.size() - 1 - $urandom_range(0, 1)] ^=
                        8'($urandom_range(1, 255));
                end
            end
            FK_EXCEPTION: begin
                tx_frame.push_back(8'($urandom_range(0, 255)));
                tx_frame.push_back(8'($urandom_range(0, 255)) | EXC_FLAG);
                append_random(1 + $urandom_range(0, 2));
                append_crc();
            end
            FK_ADDR_FUNC: begin
                if ($urandom_range(0, 1) == 1) begin
                    tx_frame.push_back(addr ^ 8'($urandom_range(1, 255)));
                    tx_frame.push_back(FUNC_READ);
                end else begin
                    fn = 8'($urandom_range(0, 127));
                    if (fn == FUNC_READ) fn = FUNC_READ + 8'd1;
                    tx_frame.push_back(addr);
                    tx_frame.push_back(fn);
                end
                tx_frame.push_back(nbytes);
                append_random(2 * nregs);
                append_crc();
            end
            FK_COUNT_BAD: begin
                tx_frame.push_back(addr);
                tx_frame.push_back(FUNC_READ);
                if ($urandom_range(0, 1) == 1) begin
                    tx_frame.push_back(nbytes ^ 8'($urandom_range(1, 255)));
                    append_random(2 * nregs);
                end else begin
                    tx_frame.push_back(nbytes);
                    append_random(($urandom_range(0, 1) == 1) ? 2 * nregs + 1 : 2 * nregs - 1);
                end
                append_crc();
            end
            FK_SHORT: begin
                append_random($urandom_range(1, 4));
            end
            FK_OVERLONG: begin
                // valid CRC over the kept part, then bytes past the store
                tx_frame.push_back(addr);
                tx_frame.push_back(FUNC_READ);
                tx_frame.push_back(nbytes);
                append_random(FRAME_CAP - 2 - 3);
                append_crc();
                append_random($urandom_range(1, 4));
            end
            default: begin
                append_random($urandom_range(5, 12));
            end
        endcase
    endtask

    // Directed: good reply under reset settings, register data at the extremes
    task automatic test_good_frame_reset_cfg();
        tx_frame = {RST_SLAVE_ADDR, FUNC_READ, 8'h04, 8'h00, 8'h00, 8'hFF, 8'hFF};
        append_crc();
        send_frame();
    endtask

    task automatic test_short_frames();
        tx_frame = {8'hFF};
        send_frame();
        tx_frame = {8'h00, 8'hAA, 8'h55, 8'hFF};
        send_frame();
    endtask

    task automatic test_crc_error();
        tx_frame = {RST_SLAVE_ADDR, FUNC_READ, 8'h00};
        append_crc();
        tx_frame[3] ^= 8'h01;
        send_frame();
    endtask

    // Exception wins even with a wrong address
    task automatic test_exception_reply();
        tx_frame = {8'h00, 8'h83, 8'h02};
        append_crc();
        send_frame();
    endtask

    task automatic test_addr_func_mismatch();
        tx_frame = {RST_SLAVE_ADDR, 8'h04, 8'h00};
        append_crc();
        send_frame();
    endtask

    // Random frames under one register setting, written while idle
    task automatic test_register_setting(input logic [7:0] addr, input logic [3:0] count,
                                         input int frames);
        wait_for_results_drained();
        write_config_reg(REG_SLAVE_ADDR, {24'd0, addr});
        write_config_reg(REG_REG_COUNT, {28'd0, count});
        for (int f = 0; f < frames; f++) begin
            build_frame((f == 0) ? FK_GOOD : pick_kind(), addr, count);
            send_frame();
        end
    endtask

    task automatic test_overlong_frame();
        build_frame(FK_OVERLONG, cfg_addr, cfg_count);
        send_frame();
    endtask

    // Last part: no idling on either side
    task automatic test_no_idle_tail();
        wait_for_results_drained();
        idle_on = 1'b0;
        test_register_setting(8'($urandom_range(0, 255)), 4'd2, 2);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rx_if.valid     = 1'b0;
        rx_if.rx_byte   = 8'h00;
        rx_if.frame_end = 1'b0;
        idle_on         = 1'b1;
        mismatch_count  = 0;
        cycle_count     = 0;
        kept            = 0;
        crc_run         = CRC_INIT;
        cfg_addr        = RST_SLAVE_ADDR;
        cfg_count       = RST_REG_COUNT;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_good_frame_reset_cfg();
        test_short_frames();
        test_crc_error();
        test_exception_reply();
        test_addr_func_mismatch();

        test_register_setting(8'h00, 4'd1, 4);
        test_register_setting(8'hFF, 4'd13, 1);
        test_register_setting(8'($urandom_range(0, 255)), 4'd0, 1);
        test_register_setting(8'($urandom_range(0, 255)), 4'd15, 1);
        test_register_setting(8'($urandom_range(0, 255)), 4'($urandom_range(1, 4)), 2);
        test_overlong_frame();
        test_no_idle_tail();

        wait_for_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mrrc_pkg.sv
hdl/mrrc_if.sv
hdl/mrrc_regs.sv
hdl/mrrc_ctrl.sv
hdl/mrrc_dpath.sv
hdl/modbus_rtu_read_response_checker.sv
bench/tb_modbus_rtu_read_response_checker.sv
